// ===== rtl/core/sbv_pkg.sv =====
// ----------------------------------------------------------------------------
// sbv_pkg
// Shared types and constants of the segment versus box visibility test.
// ----------------------------------------------------------------------------
`default_nettype none

package sbv_pkg;

   // Default configuration of the block.
   localparam int DEF_MAX_BOXES  = 3;
   localparam int DEF_COORD_BITS = 11;

   // Configuration port geometry.
   localparam int CSR_INDEX_BITS = 2;
   localparam int COUNT_BITS     = 2;

   // The result carries one bit, padded to a byte.
   localparam int RSP_TDATA_BITS = 8;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_OBSTACLE_COUNT = 2'd0,
      REG_BOX_ZERO       = 2'd1,
      REG_BOX_ONE        = 2'd2,
      REG_BOX_TWO        = 2'd3
   } csr_reg_type;

   // Shape of the segment, shared by every box lane.
   typedef struct packed {
      logic same_point;
      logic dx_zero;
      logic dy_zero;
   } seg_flags_type;

endpackage

`default_nettype wire

// ===== rtl/core/sbv_csr.sv =====
// ----------------------------------------------------------------------------
// sbv_csr
// Configuration registers: obstacle count and the packed box corners.
// ----------------------------------------------------------------------------
`default_nettype none

module sbv_csr #(
   parameter int MAX_BOXES  = sbv_pkg::DEF_MAX_BOXES,
   parameter int COORD_BITS = sbv_pkg::DEF_COORD_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [sbv_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [4*COORD_BITS-1:0]             csr_wdata,
   output logic      [MAX_BOXES-1:0][4*COORD_BITS-1:0] box,
   output logic      [MAX_BOXES-1:0]                box_en
);

   localparam int BOX_BITS = 4 * COORD_BITS;
   // Only three box registers exist in the register map.
   localparam int MAP_BOXES = 3;

   logic [sbv_pkg::COUNT_BITS-1:0] count_ff;
   logic [sbv_pkg::COUNT_BITS-1:0] count_in;
   logic [MAX_BOXES-1:0][BOX_BITS-1:0] box_ff;
   logic [MAX_BOXES-1:0][BOX_BITS-1:0] box_in;

   always_comb begin
      count_in = count_ff;
      box_in   = box_ff;
      if (csr_we) begin
         if (csr_index == sbv_pkg::REG_OBSTACLE_COUNT) begin
            count_in = csr_wdata[sbv_pkg::COUNT_BITS-1:0];
         end
         for (int k = 0; k < MAX_BOXES; k++) begin
            if (k < MAP_BOXES &&
                csr_index == sbv_pkg::CSR_INDEX_BITS'(int'(sbv_pkg::REG_BOX_ZERO) + k)) begin
               box_in[k] = csr_wdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         box_ff   <= '0;
      end else begin
         count_ff <= count_in;
         box_ff   <= box_in;
      end
   end

   // A lane takes part only while its box number is below the count.
   always_comb begin
      for (int k = 0; k < MAX_BOXES; k++) begin
         box_en[k] = (k < int'(count_ff));
      end
   end

   assign box = box_ff;

endmodule

`default_nettype wire

// ===== rtl/core/sbv_box_lane.sv =====
// ----------------------------------------------------------------------------
// sbv_box_lane
// One obstacle box: registered cross products, then the edge decisions.
// ----------------------------------------------------------------------------
`default_nettype none

module sbv_box_lane #(
   parameter int COORD_BITS = sbv_pkg::DEF_COORD_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          load,
   input  wire logic signed [COORD_BITS-1:0]  ax,
   input  wire logic signed [COORD_BITS-1:0]  ay,
   input  wire logic signed [COORD_BITS-1:0]  bx,
   input  wire logic signed [COORD_BITS-1:0]  by,
   input  wire logic [4*COORD_BITS-1:0]       box,
   input  wire logic                          box_en,
   input  wire sbv_pkg::seg_flags_type        flags,
   output logic                               blocked
);

   localparam int D = COORD_BITS + 1;
   localparam int P = 2 * COORD_BITS + 2;

   logic signed [COORD_BITS-1:0] left, top, right, bottom;
   logic signed [COORD_BITS-1:0] lo_x, hi_x, lo_y, hi_y;
   logic signed [D-1:0] dx, dy, adx, ady, sdx, sdy;
   logic signed [D-1:0] lx, rx, ty, by_d;

   logic signed [P-1:0] p_sl_ff, p_sl_in, p_sr_ff, p_sr_in;
   logic signed [P-1:0] p_ta_ff, p_ta_in, p_ba_ff, p_ba_in;
   logic signed [P-1:0] p_st_ff, p_st_in, p_sb_ff, p_sb_in;
   logic signed [P-1:0] p_ld_ff, p_ld_in, p_rd_ff, p_rd_in;
   logic left_x_ff, left_x_in, right_x_ff, right_x_in;
   logic top_y_ff, top_y_in, bot_y_ff, bot_y_in;
   logic x_box_ff, x_box_in;
   logic en_ff;

   always_comb begin
      left   = $signed(box[COORD_BITS-1:0]);
      top    = $signed(box[2*COORD_BITS-1:COORD_BITS]);
      right  = $signed(box[3*COORD_BITS-1:2*COORD_BITS]);
      bottom = $signed(box[4*COORD_BITS-1:3*COORD_BITS]);

      lo_x = (ax < bx) ? ax : bx;
      hi_x = (ax < bx) ? bx : ax;
      lo_y = (ay < by) ? ay : by;
      hi_y = (ay < by) ? by : ay;

      dx   = D'(bx) - D'(ax);
      dy   = D'(by) - D'(ay);
      adx  = dx[D-1] ? -dx : dx;
      sdy  = dx[D-1] ? -dy : dy;
      ady  = dy[D-1] ? -dy : dy;
      sdx  = dy[D-1] ? -dx : dx;
      lx   = D'(left) - D'(ax);
      rx   = D'(right) - D'(ax);
      ty   = D'(top) - D'(ay);
      by_d = D'(bottom) - D'(ay);

      // Vertical edges: segment y at the edge, scaled by |dx|.
      p_sl_in = P'(sdy) * P'(lx);
      p_sr_in = P'(sdy) * P'(rx);
      p_ta_in = P'(ty) * P'(adx);
      p_ba_in = P'(by_d) * P'(adx);
      // Horizontal edges: segment x at the edge, scaled by |dy|.
      p_st_in = P'(sdx) * P'(ty);
      p_sb_in = P'(sdx) * P'(by_d);
      p_ld_in = P'(lx) * P'(ady);
      p_rd_in = P'(rx) * P'(ady);

      left_x_in  = (left >= lo_x) && (left <= hi_x);
      right_x_in = (right >= lo_x) && (right <= hi_x);
      top_y_in   = (top >= lo_y) && (top <= hi_y);
      bot_y_in   = (bottom >= lo_y) && (bottom <= hi_y);
      x_box_in   = (left <= ax) && (ax <= right);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= 1'b0;
      end else if (load) begin
         en_ff <= box_en;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         p_sl_ff    <= p_sl_in;
         p_sr_ff    <= p_sr_in;
         p_ta_ff    <= p_ta_in;
         p_ba_ff    <= p_ba_in;
         p_st_ff    <= p_st_in;
         p_sb_ff    <= p_sb_in;
         p_ld_ff    <= p_ld_in;
         p_rd_ff    <= p_rd_in;
         left_x_ff  <= left_x_in;
         right_x_ff <= right_x_in;
         top_y_ff   <= top_y_in;
         bot_y_ff   <= bot_y_in;
         x_box_ff   <= x_box_in;
      end
   end

   logic hit_vert, hit_left, hit_right, hit_top, hit_bot;

   always_comb begin
      hit_vert  = x_box_ff && (top_y_ff || bot_y_ff);
      hit_left  = left_x_ff && (p_ta_ff <= p_sl_ff) && (p_sl_ff <= p_ba_ff);
      hit_right = right_x_ff && (p_ta_ff <= p_sr_ff) && (p_sr_ff <= p_ba_ff);
      hit_top   = top_y_ff && (p_ld_ff <= p_st_ff) && (p_st_ff <= p_rd_ff);
      hit_bot   = bot_y_ff && (p_ld_ff <= p_sb_ff) && (p_sb_ff <= p_rd_ff);

      if (!en_ff) begin
         blocked = 1'b0;
      end else if (flags.dx_zero) begin
         blocked = hit_vert;
      end else begin
         // A horizontal segment never tests the top and bottom edges.
         blocked = hit_left || hit_right ||
                   (!flags.dy_zero && (hit_top || hit_bot));
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/segment_box_visibility_test_top.sv =====
// ----------------------------------------------------------------------------
// segment_box_visibility_test_top
// Tests whether a segment between two points clears the obstacle boxes.
// ----------------------------------------------------------------------------
// Usage:
// A request on req_* carries the two segment ends; one response on rsp_*
// follows for every request, in order, with clear_path set when no box in
// use touches the segment. Boxes and the obstacle count are loaded through
// csr_*; the user must do so only while no request is in flight, which the
// block itself does not enforce. The block is a three-register pipeline:
// input register, the per-box cross products (one multiplier per product, all
// boxes in parallel), and the response register. A new request is taken
// every cycle while the receiver does not stall. When the receiver stalls,
// the response register holds and the earlier stages keep filling until all
// three are occupied; req_tready stays high whenever the response register
// is empty or being taken.
// Reset empties the pipeline, sets the obstacle count to zero and clears
// all boxes to the origin.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_box_visibility_test_top #(
   parameter int MAX_BOXES  = sbv_pkg::DEF_MAX_BOXES,
   parameter int COORD_BITS = sbv_pkg::DEF_COORD_BITS
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_tvalid,
   output logic                                          req_tready,
   // first_x, first_y, second_x, second_y, zero padding
   input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]        req_tdata,
   output logic                                          rsp_tvalid,
   input  wire logic                                     rsp_tready,
   // clear_path, zero padding
   output logic [sbv_pkg::RSP_TDATA_BITS-1:0]            rsp_tdata,
   input  wire logic                                     csr_we,
   input  wire logic [sbv_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  wire logic [4*COORD_BITS-1:0]                  csr_wdata
);

   localparam int C = COORD_BITS;

   logic [MAX_BOXES-1:0][4*C-1:0] box;
   logic [MAX_BOXES-1:0]          box_en;
   logic [MAX_BOXES-1:0]          blocked;

   sbv_csr #(
      .MAX_BOXES (MAX_BOXES),
      .COORD_BITS(COORD_BITS)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .box      (box),
      .box_en   (box_en)
   );

   // Stage handshakes: each stage loads when it is empty or moving on.
   logic ready1, ready2, ready3;
   logic s1_valid_ff, s2_valid_ff, out_valid_ff;
   logic signed [C-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   sbv_pkg::seg_flags_type flags_ff, flags_in;
   logic clear_ff, clear_in;

   assign ready3     = !out_valid_ff || rsp_tready;
   assign ready2     = !s2_valid_ff || ready3;
   assign ready1     = !s1_valid_ff || ready2;
   assign req_tready = ready1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (ready1) begin
            s1_valid_ff <= req_tvalid;
         end
         if (ready2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (ready3) begin
            out_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         ax_ff <= $signed(req_tdata[C-1:0]);
         ay_ff <= $signed(req_tdata[2*C-1:C]);
         bx_ff <= $signed(req_tdata[3*C-1:2*C]);
         by_ff <= $signed(req_tdata[4*C-1:3*C]);
      end
   end

   always_comb begin
      flags_in.dx_zero    = (ax_ff == bx_ff);
      flags_in.dy_zero    = (ay_ff == by_ff);
      flags_in.same_point = flags_in.dx_zero && flags_in.dy_zero;
   end

   always_ff @(posedge clock) begin
      if (ready2) begin
         flags_ff <= flags_in;
      end
   end

   for (genvar k = 0; k < MAX_BOXES; k++) begin : g_lane
      sbv_box_lane #(
         .COORD_BITS(COORD_BITS)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .load   (ready2),
         .ax     (ax_ff),
         .ay     (ay_ff),
         .bx     (bx_ff),
         .by     (by_ff),
         .box    (box[k]),
         .box_en (box_en[k]),
         .flags  (flags_ff),
         .blocked(blocked[k])
      );
   end

   // Identical ends never count as a clear path.
   assign clear_in = !flags_ff.same_point && (blocked == '0);

   always_ff @(posedge clock) begin
      if (ready3) begin
         clear_ff <= clear_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = sbv_pkg::RSP_TDATA_BITS'(clear_ff);

endmodule

`default_nettype wire

// ===== rtl/core/sbv_checker.sv =====
// ----------------------------------------------------------------------------
// sbv_checker
// Port-level checks of the visibility test, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sbv_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tready,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [sbv_pkg::RSP_TDATA_BITS-1:0]  rsp_tdata
);

   // The pipeline comes out of reset empty.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // With the response register free, a request is always taken.
   a_ready_when_free : assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("request stalled with a free response register");

   // A stalled response holds its value.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

   // Only the lowest response bit carries data.
   a_rsp_pad : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[sbv_pkg::RSP_TDATA_BITS-1:1] == '0))
      else $error("response padding not zero");

endmodule

bind segment_box_visibility_test_top sbv_checker u_sbv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the segment versus box obstacle visibility test.
// ----------------------------------------------------------------------------
// Segment requests go in on req_* in random bursts while the response side
// stalls on a rotating pattern, with two long holds that back the pipeline
// up into the request side. A scoreboard predicts clear_path for every
// accepted request using exact integer cross products against its own copy
// of the box registers, and compares responses in order. The box registers
// are reloaded between phases only once the pipeline has drained.
// ----------------------------------------------------------------------------

module tb_top;

   localparam int CW               = sbv_pkg::DEF_COORD_BITS;
   localparam int NUM_BOXES        = sbv_pkg::DEF_MAX_BOXES;
   localparam int RANDOM_PHASES    = 10;
   localparam int ITEMS_PER_PHASE  = 55;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT      = 200000;

   // Packed from the lowest bit up: first_x, first_y, second_x, second_y, padding.
   typedef struct packed {
      logic [3:0]           pad;
      logic signed [CW-1:0] second_y;
      logic signed [CW-1:0] second_x;
      logic signed [CW-1:0] first_y;
      logic signed [CW-1:0] first_x;
   } segment_req_type;

   // Packed from the lowest bit up: left, top, right, bottom.
   typedef struct packed {
      logic signed [CW-1:0] bottom;
      logic signed [CW-1:0] right;
      logic signed [CW-1:0] top;
      logic signed [CW-1:0] left;
   } box_word_type;

   class clear_path_scoreboard;
      logic [sbv_pkg::COUNT_BITS-1:0] box_count;
      longint box_left[NUM_BOXES];
      longint box_top[NUM_BOXES];
      longint box_right[NUM_BOXES];
      longint box_bottom[NUM_BOXES];
      bit expected_clear_path[$];
      int unsigned mismatches;
      int unsigned stray_responses;
      int unsigned responses_checked;
      int unsigned blocked_seen;

      function new();
         int k;
         box_count = '0;
         for (k = 0; k < NUM_BOXES; k++) begin
            box_left[k] = 0;
            box_top[k] = 0;
            box_right[k] = 0;
            box_bottom[k] = 0;
         end
         mismatches = 0;
         stray_responses = 0;
         responses_checked = 0;
         blocked_seen = 0;
      endfunction

      function void set_count(logic [sbv_pkg::COUNT_BITS-1:0] count);
         box_count = count;
      endfunction

      function void set_box(int k, box_word_type w);
         box_left[k]   = longint'($signed(w.left));
         box_top[k]    = longint'($signed(w.top));
         box_right[k]  = longint'($signed(w.right));
         box_bottom[k] = longint'($signed(w.bottom));
      endfunction

      function bit box_blocks_segment(int k, longint ax, longint ay, longint bx, longint by);
         longint l, t, r, b;
         longint lo_x, hi_x, lo_y, hi_y, dx, dy;
         longint a_span, s_span, num, e;
         int i;
         l = box_left[k];
         t = box_top[k];
         r = box_right[k];
         b = box_bottom[k];
         lo_x = (ax < bx) ? ax : bx;
         hi_x = (ax < bx) ? bx : ax;
         lo_y = (ay < by) ? ay : by;
         hi_y = (ay < by) ? by : ay;
         dx = bx - ax;
         dy = by - ay;
         if (dx == 0) begin
            return (l <= ax && ax <= r) &&
                   ((lo_y <= t && t <= hi_y) || (lo_y <= b && b <= hi_y));
         end
         // Vertical edges: y at the edge, scaled by |dx| to stay in integers.
         a_span = (dx < 0) ? -dx : dx;
         s_span = (dx < 0) ? -dy : dy;
         for (i = 0; i < 2; i++) begin
            e = (i == 0) ? l : r;
            if (e >= lo_x && e <= hi_x) begin
               num = s_span * (e - ax);
               if ((t - ay) * a_span <= num && num <= (b - ay) * a_span)
                  return 1'b1;
            end
         end
         // A horizontal segment never takes the top and bottom edge tests.
         if (dy == 0)
            return 1'b0;
         a_span = (dy < 0) ? -dy : dy;
         s_span = (dy < 0) ? -dx : dx;
         for (i = 0; i < 2; i++) begin
            e = (i == 0) ? t : b;
            if (e >= lo_y && e <= hi_y) begin
               num = s_span * (e - ay);
               if ((l - ax) * a_span <= num && num <= (r - ax) * a_span)
                  return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function bit predict_clear_path(segment_req_type s);
         longint ax, ay, bx, by;
         int k;
         ax = longint'($signed(s.first_x));
         ay = longint'($signed(s.first_y));
         bx = longint'($signed(s.second_x));
         by = longint'($signed(s.second_y));
         if (ax == bx && ay == by)
            return 1'b0;
         for (k = 0; k < NUM_BOXES && k < int'(box_count); k++) begin
            if (box_blocks_segment(k, ax, ay, bx, by))
               return 1'b0;
         end
         return 1'b1;
      endfunction

      function void note_request(segment_req_type s);
         expected_clear_path = {expected_clear_path, predict_clear_path(s)};
      endfunction

      function void check_response(logic clear_path);
         bit want;
         responses_checked++;
         if (expected_clear_path.size() == 0) begin
            stray_responses++;
            if (mismatches + stray_responses <= 10)
               $display("tb_top: response %0d arrived with no request waiting",
                        responses_checked);
            return;
         end
         want = expected_clear_path.pop_front();
         if (!want)
            blocked_seen++;
         if (clear_path !== want) begin
            mismatches++;
            if (mismatches + stray_responses <= 10)
               $display("tb_top: mismatch on response %0d: clear_path expected %0b, got %0b",
                        responses_checked, want, clear_path);
         end
      endfunction

      function int pending();
         return expected_clear_path.size();
      endfunction

      function int unsigned failures();
         return mismatches + stray_responses + expected_clear_path.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   // first_x, first_y, second_x, second_y, zero padding
   logic [47:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   // clear_path, zero padding
   logic [sbv_pkg::RSP_TDATA_BITS-1:0] rsp_tdata;
   logic csr_we;
   logic [sbv_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [4*CW-1:0] csr_wdata;

   clear_path_scoreboard sb = new();

   box_word_type cur_boxes[NUM_BOXES];
   int unsigned burst_left;
   int unsigned settings_loaded;
   int unsigned requests_sent;
   int unsigned long_holds;
   int unsigned cycle_count;
   int unsigned rsp_cycle;
   bit long_hold_req;

   segment_box_visibility_test_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: timeout after %0d cycles", cycle_count);
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // Both handshakes are sampled here with their values from before the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(segment_req_type'(req_tdata));
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tdata[0]);
      end
   end

   // Response side: a rotating stall pattern, plus long holds on request.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_cycle++;
         if (long_hold_req) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold_req = 1'b0;
            long_holds++;
         end else begin
            case ((rsp_cycle / 40) % 4)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2: rsp_tready <= ((rsp_cycle % 2) == 0) || ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ($urandom_range(0, 9) < 3);
            endcase
         end
      end
   end

   task automatic send_segment(input segment_req_type s);
      int unsigned gap;
      if (burst_left == 0) begin
         case ($urandom_range(0, 9))
            0, 1: gap = 0;
            2, 3, 4, 5, 6: gap = $urandom_range(1, 3);
            default: gap = $urandom_range(4, 12);
         endcase
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      s.pad = '0;
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      requests_sent++;
   endtask

   task automatic send_points(input int ax, input int ay, input int bx, input int by);
      segment_req_type s;
      s.pad = '0;
      s.first_x = CW'(ax);
      s.first_y = CW'(ay);
      s.second_x = CW'(bx);
      s.second_y = CW'(by);
      send_segment(s);
   endtask

   // One edge passes first so that the last accepted request is noted.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_config(input logic [sbv_pkg::COUNT_BITS-1:0] count,
                              input box_word_type b0, input box_word_type b1,
                              input box_word_type b2);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= sbv_pkg::REG_OBSTACLE_COUNT;
      csr_wdata <= {{(4*CW-sbv_pkg::COUNT_BITS){1'b0}}, count};
      @(posedge clock);
      csr_index <= sbv_pkg::REG_BOX_ZERO;
      csr_wdata <= b0;
      @(posedge clock);
      csr_index <= sbv_pkg::REG_BOX_ONE;
      csr_wdata <= b1;
      @(posedge clock);
      csr_index <= sbv_pkg::REG_BOX_TWO;
      csr_wdata <= b2;
      @(posedge clock);
      csr_we <= 1'b0;
      cur_boxes[0] = b0;
      cur_boxes[1] = b1;
      cur_boxes[2] = b2;
      sb.set_count(count);
      sb.set_box(0, b0);
      sb.set_box(1, b1);
      sb.set_box(2, b2);
      settings_loaded++;
   endtask

   function automatic box_word_type make_box(bit force_extreme);
      box_word_type w;
      int a, b, span, mode;
      mode = force_extreme ? 0 : int'($urandom_range(0, 9));
      case (mode)
         0: begin
            w.left   = CW'($urandom_range(0, 1) ? -1024 : 1023);
            w.top    = CW'($urandom_range(0, 1) ? -1024 : 1023);
            w.right  = CW'($urandom_range(0, 1) ? -1024 : 1023);
            w.bottom = CW'($urandom_range(0, 1) ? -1024 : 1023);
         end
         1: w = (4*CW)'({$urandom, $urandom});
         2: begin
            // Degenerate: zero width or zero height.
            a = int'($urandom_range(0, 2047)) - 1024;
            b = int'($urandom_range(0, 2047)) - 1024;
            w.left = CW'(a);
            w.right = CW'($urandom_range(0, 1) ? a : a + int'($urandom_range(0, 200)));
            w.top = CW'(b);
            w.bottom = (w.right == w.left) ? CW'(b + int'($urandom_range(0, 200))) : CW'(b);
            if (w.right < w.left) w.right = w.left;
            if (w.bottom < w.top) w.bottom = w.top;
         end
         3: begin
            // Inverted in x, and on some draws in y as well.
            a = int'($urandom_range(0, 1800)) - 1024;
            b = int'($urandom_range(0, 1800)) - 1024;
            span = int'($urandom_range(1, 200));
            w.left = CW'(a + span);
            w.right = CW'(a);
            w.top = CW'($urandom_range(0, 1) ? b + span : b);
            w.bottom = CW'(b + ((w.top == b) ? span : 0));
         end
         default: begin
            span = (mode < 7) ? int'($urandom_range(0, 300)) : int'($urandom_range(0, 2047));
            a = int'($urandom_range(0, 2047 - span)) - 1024;
            w.left = CW'(a);
            w.right = CW'(a + span);
            span = (mode < 7) ? int'($urandom_range(0, 300)) : int'($urandom_range(0, 2047));
            b = int'($urandom_range(0, 2047 - span)) - 1024;
            w.top = CW'(b);
            w.bottom = CW'(b + span);
         end
      endcase
      return w;
   endfunction

   // Coordinates cluster on the box edges so that corner and end cases get hit.
   function automatic logic signed [CW-1:0] pick_coord(bit along_x);
      box_word_type w;
      int r;
      logic signed [CW-1:0] c;
      r = $urandom_range(0, 99);
      w = cur_boxes[$urandom_range(0, NUM_BOXES - 1)];
      if (r < 35) begin
         c = CW'($urandom);
      end else if (r < 50) begin
         case ($urandom_range(0, 3))
            0: c = CW'(-1024);
            1: c = CW'(1023);
            2: c = CW'(0);
            default: c = CW'(-1);
         endcase
      end else begin
         if (along_x)
            c = $urandom_range(0, 1) ? w.left : w.right;
         else
            c = $urandom_range(0, 1) ? w.top : w.bottom;
         c = c + CW'(int'($urandom_range(0, 6)) - 3);
      end
      return c;
   endfunction

   function automatic segment_req_type make_segment();
      segment_req_type s;
      int r;
      s.pad = '0;
      s.first_x = pick_coord(1'b1);
      s.first_y = pick_coord(1'b0);
      s.second_x = pick_coord(1'b1);
      s.second_y = pick_coord(1'b0);
      r = $urandom_range(0, 99);
      if (r < 5) begin
         s.second_x = s.first_x;
         s.second_y = s.first_y;
      end else if (r < 25) begin
         s.second_x = s.first_x;
      end else if (r < 45) begin
         s.second_y = s.first_y;
      end
      return s;
   endfunction

   initial begin
      int p, n;
      logic [sbv_pkg::COUNT_BITS-1:0] count;
      box_word_type b0, b1, b2;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_index  <= sbv_pkg::REG_OBSTACLE_COUNT;
      csr_wdata  <= '0;
      cur_boxes[0] = '0;
      cur_boxes[1] = '0;
      cur_boxes[2] = '0;
      burst_left = 0;
      long_hold_req = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Out of reset no box is in use: only identical points are not clear.
      send_points(0, 0, 0, 0);
      send_points(-1024, 1023, 1023, -1024);
      send_points(17, -3, 17, 400);

      b0 = {11'sd50, 11'sd100, -11'sd50, -11'sd100};
      b1 = {11'sd300, 11'sd150, -11'sd300, 11'sd200};   // left above right
      b2 = {11'sd1023, 11'sd1023, -11'sd1024, -11'sd1024};
      load_config(2'd3, b0, b1, b2);
      send_points(5, 5, 5, 5);                   // identical points
      send_points(-1024, -1024, -1024, -1024);   // identical points at the corner
      send_points(0, -200, 0, 200);              // vertical through a box
      send_points(0, -10, 0, 10);                // vertical inside a box
      send_points(100, 50, 100, 400);            // vertical starting on a corner
      send_points(-101, -200, -101, 200);        // vertical just outside
      send_points(-200, 0, -20, 0);              // horizontal onto the left edge
      send_points(-300, -50, -101, -50);         // horizontal along an edge line
      send_points(-100, -50, 100, 50);           // diagonal corner to corner
      send_points(-1024, -1024, 1023, 1023);     // full-range diagonal
      send_points(1023, -1024, -1024, 1023);     // full-range anti-diagonal
      send_points(-1024, 1023, 1023, 1023);      // horizontal on the outer bottom
      send_points(1023, -1024, 1023, 1023);      // vertical on the outer right
      send_points(99, 60, 110, 40);              // skims a corner
      send_points(-1, -500, 1, 500);             // steep crossing
      send_points(-200, -100, 200, 100);         // reversed direction

      // An all-ones word is a single point box at (-1, -1).
      load_config(2'd1, '1, b1, b2);
      send_points(-5, -5, 5, 5);
      send_points(-1, -300, -1, -2);
      send_points(-1, -1, 40, -1);

      for (p = 0; p < RANDOM_PHASES; p++) begin
         count = (p == 0) ? 2'd3 : (p == 1) ? 2'd0 : 2'($urandom_range(0, 3));
         b0 = make_box(p == 0);
         b1 = make_box(p == 0);
         b2 = make_box(1'b0);
         load_config(count, b0, b1, b2);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ((p == 2 || p == 6) && n == 20 && !long_hold_req)
               long_hold_req = 1'b1;
            send_segment(make_segment());
         end
      end

      wait_idle();
      repeat (8) @(posedge clock);

      $display("tb_top: %0d segment requests over %0d register settings, %0d responses",
               requests_sent, settings_loaded, sb.responses_checked);
      $display("tb_top: %0d blocked, %0d long response holds, %0d mismatches",
               sb.blocked_seen, long_holds, sb.mismatches + sb.stray_responses);
      if (sb.failures() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule

// ===== segment_box_visibility_test_top.f =====
rtl/core/sbv_pkg.sv
rtl/core/sbv_csr.sv
rtl/core/sbv_box_lane.sv
rtl/core/segment_box_visibility_test_top.sv
rtl/core/sbv_checker.sv
tb/tb_top.sv
